### rtl/pls_pkg.sv
// Shared types, widths and codes of the positional list store.
package pls_pkg;

  localparam int DEPTH = 16;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int TOT_W  = 7;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int S_TDATA_W = ((OP_W + VAL_W + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((VAL_W + STAT_W + TOT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_INS_AT    = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADPOS = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DUMP = 2'd2
  } state_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic dump_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_nonempty;
    logic dump_last;
  } sts_t;

endpackage

### rtl/pls_ctrl.sv
// Controller state machine: sequences capture, edit and dump of one item.
module pls_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  pls_pkg::sts_t    sts_i,
  output pls_pkg::cmd_t    cmd_o
);

  pls_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pls_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pls_pkg::S_IDLE: begin
        if (s_tvalid_i) state_d = pls_pkg::S_EXEC;
      end
      pls_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = sts_i.dump_nonempty ? pls_pkg::S_DUMP : pls_pkg::S_IDLE;
        end
      end
      pls_pkg::S_DUMP: begin
        if (sts_i.out_free && sts_i.dump_last) state_d = pls_pkg::S_IDLE;
      end
      default: state_d = pls_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o        = 1'b0;
    cmd_o             = '0;
    unique case (state_q)
      pls_pkg::S_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.load_in = s_tvalid_i;
      end
      pls_pkg::S_EXEC: begin
        cmd_o.exec    = sts_i.out_free && !sts_i.dump_nonempty;
      end
      pls_pkg::S_DUMP: begin
        cmd_o.dump_emit = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

### rtl/pls_dp.sv
// Datapath: item registers, shifting cell chain, count and output register.
module pls_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pls_pkg::cmd_t                 cmd_i,
  output pls_pkg::sts_t                 sts_o,
  input  logic [pls_pkg::S_TDATA_W-1:0] in_tdata_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [pls_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic                          m_tuser_o,
  output logic                          m_tlast_o
);

  localparam int OP_LSB  = 0;
  localparam int VAL_LSB = OP_LSB + pls_pkg::OP_W;
  localparam int POS_LSB = VAL_LSB + pls_pkg::VAL_W;

  pls_pkg::op_e                 op_q;
  logic [pls_pkg::VAL_W-1:0]    value_q;
  logic [pls_pkg::POS_W-1:0]    pos_q;

  logic [pls_pkg::CNT_W-1:0]    count_q, count_d;
  logic [pls_pkg::IDX_W-1:0]    dump_idx_q;
  logic [pls_pkg::VAL_W-1:0]    cell_q [pls_pkg::DEPTH];

  logic                         out_valid_q;
  logic [pls_pkg::VAL_W-1:0]    out_elem_q;
  pls_pkg::stat_e               out_stat_q;
  logic [pls_pkg::TOT_W-1:0]    out_tot_q;
  logic                         out_user_q;
  logic                         out_last_q;

  pls_pkg::stat_e               status;
  logic                         do_ins, do_del;
  logic [pls_pkg::IDX_W-1:0]    idx;
  logic                         full, empty;
  logic [pls_pkg::CNT_W-1:0]    count_m1;
  logic [pls_pkg::POS_W-1:0]    cnt_ext, pos_m1;
  logic [pls_pkg::CNT_W-1:0]    dump_next;

  // Item capture; payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= pls_pkg::op_e'(in_tdata_i[OP_LSB +: pls_pkg::OP_W]);
      value_q <= in_tdata_i[VAL_LSB +: pls_pkg::VAL_W];
      pos_q   <= in_tdata_i[POS_LSB +: pls_pkg::POS_W];
    end
  end

  assign full     = (count_q == pls_pkg::CNT_W'(pls_pkg::DEPTH));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - pls_pkg::CNT_W'(1);
  assign cnt_ext  = pls_pkg::POS_W'(count_q);
  assign pos_m1   = pos_q - pls_pkg::POS_W'(1);

  // Decode the edit; full/empty take priority over the position check.
  always_comb begin
    status = pls_pkg::STAT_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    unique case (op_q)
      pls_pkg::OP_INS_FRONT: begin
        if (full) status = pls_pkg::STAT_FULL;
        else do_ins = 1'b1;
      end
      pls_pkg::OP_INS_BACK: begin
        idx = count_q[pls_pkg::IDX_W-1:0];
        if (full) status = pls_pkg::STAT_FULL;
        else do_ins = 1'b1;
      end
      pls_pkg::OP_DEL_FRONT: begin
        if (empty) status = pls_pkg::STAT_EMPTY;
        else do_del = 1'b1;
      end
      pls_pkg::OP_DEL_BACK: begin
        idx = count_m1[pls_pkg::IDX_W-1:0];
        if (empty) status = pls_pkg::STAT_EMPTY;
        else do_del = 1'b1;
      end
      pls_pkg::OP_INS_AT: begin
        idx = pos_m1[pls_pkg::IDX_W-1:0];
        if (full) status = pls_pkg::STAT_FULL;
        else if (pos_q == '0 || pos_q > cnt_ext + pls_pkg::POS_W'(1))
          status = pls_pkg::STAT_BADPOS;
        else do_ins = 1'b1;
      end
      pls_pkg::OP_DEL_AT: begin
        idx = pos_m1[pls_pkg::IDX_W-1:0];
        if (empty) status = pls_pkg::STAT_EMPTY;
        else if (pos_q == '0 || pos_q > cnt_ext)
          status = pls_pkg::STAT_BADPOS;
        else do_del = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + pls_pkg::CNT_W'(1);
    else if (do_del) count_d = count_m1;
  end

  // Cell chain: cells above idx shift up on insert, from idx down on delete.
  for (genvar g = 0; g < pls_pkg::DEPTH; g++) begin : g_cell
    logic [pls_pkg::VAL_W-1:0] from_lo, from_hi;
    if (g == 0) begin : g_lo_first
      assign from_lo = value_q;
    end else begin : g_lo_rest
      assign from_lo = cell_q[g-1];
    end
    if (g == pls_pkg::DEPTH - 1) begin : g_hi_last
      assign from_hi = cell_q[g];
    end else begin : g_hi_rest
      assign from_hi = cell_q[g+1];
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        if (do_ins && pls_pkg::IDX_W'(g) == idx) cell_q[g] <= value_q;
        else if (do_ins && pls_pkg::IDX_W'(g) > idx) cell_q[g] <= from_lo;
        else if (do_del && pls_pkg::IDX_W'(g) >= idx) cell_q[g] <= from_hi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      dump_idx_q <= '0;
    end else begin
      if (cmd_i.exec) count_q <= count_d;
      if (cmd_i.load_in) dump_idx_q <= '0;
      else if (cmd_i.dump_emit) dump_idx_q <= dump_idx_q + pls_pkg::IDX_W'(1);
    end
  end

  assign dump_next = pls_pkg::CNT_W'(dump_idx_q) + pls_pkg::CNT_W'(1);

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec || cmd_i.dump_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_elem_q <= '0;
      out_user_q <= 1'b0;
      out_stat_q <= status;
      out_tot_q  <= pls_pkg::TOT_W'(count_d);
      out_last_q <= 1'b1;
    end else if (cmd_i.dump_emit) begin
      out_elem_q <= cell_q[dump_idx_q];
      out_user_q <= 1'b1;
      out_stat_q <= pls_pkg::STAT_OK;
      out_tot_q  <= pls_pkg::TOT_W'(count_q);
      out_last_q <= (dump_next == count_q);
    end
  end

  assign sts_o.out_free      = !out_valid_q || m_tready_i;
  assign sts_o.dump_nonempty = (op_q == pls_pkg::OP_DUMP) && !empty;
  assign sts_o.dump_last     = (dump_next == count_q);

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = pls_pkg::M_TDATA_W'({out_tot_q, out_stat_q, out_elem_q});
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

endmodule

### rtl/positional_list_store.sv
// Top level of the positional list store: controller plus datapath.
//
// Holds an ordered list of up to 16 signed 32-bit values in a chain of
// registers that shifts by one place on insert and delete. Each input beat
// carries one operation: insert front/back, delete front/back, insert or
// delete at a 1-based position, or dump. Every edit returns exactly one
// output beat (tuser low, tlast high) with its status and the count after
// the edit; insert when full, delete when empty and a bad position are
// flagged and leave the list untouched. Dump returns one beat per stored
// element in order (tuser high), tlast on the last; a dump of an empty list
// returns one beat with tuser low. The controller captures a beat in its
// idle state and applies the edit in its execute state; a dump then reads
// the chain one cell per cycle through the output register while the
// output is not stalled. The output register holds a result while the
// next input beat is taken; backpressure stalls the edit or dump step,
// never drops it. No clearing pass follows reset: cells above the count
// are never read.
module positional_list_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // operation [2:0], value [34:3], position [41:35], zero fill above
  input  logic [pls_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // element [31:0], status [33:32], entry_total [40:34], zero fill above
  output logic [pls_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // element_valid [0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);

  pls_pkg::cmd_t cmd;
  pls_pkg::sts_t sts;

  // Sequence each beat: capture, apply or stream.
  pls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the list, the count and the pending output beat.
  pls_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_tdata_i (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

### rtl/pls_checker.sv
// Port-level checks of the positional list store, bound to the top level.
module pls_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pls_pkg::M_TDATA_W-1:0] m_tdata_i,
  input  logic                          m_tuser_i,
  input  logic                          m_tlast_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i
);

  logic [pls_pkg::STAT_W-1:0] stat;
  logic [pls_pkg::TOT_W-1:0]  tot;

  assign stat = m_tdata_i[pls_pkg::VAL_W +: pls_pkg::STAT_W];
  assign tot  = m_tdata_i[pls_pkg::VAL_W + pls_pkg::STAT_W +: pls_pkg::TOT_W];

  // Edit results are single beats.
  a_edit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tuser_i |-> m_tlast_i)
    else $error("edit result beat without tlast");

  // Dumped elements always report success.
  a_dump_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> stat == pls_pkg::STAT_OK)
    else $error("dump beat with error status");

  // Full refusal only at capacity, empty refusal only at zero.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && stat == pls_pkg::STAT_FULL |->
      tot == pls_pkg::TOT_W'(pls_pkg::DEPTH))
    else $error("full status below capacity");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && stat == pls_pkg::STAT_EMPTY |-> tot == '0)
    else $error("empty status with stored elements");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("output beat changed under backpressure");

endmodule

bind positional_list_store pls_checker u_pls_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser),
  .m_tlast_i  (m_axis_tlast),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready)
);
